### rtl/lane_change_planner_top_assert.svh
// Assertion macros for the lane change planner.
// Each macro checks under clk with the synchronous active-low reset rst_n.
`ifndef LANE_CHANGE_PLANNER_TOP_ASSERT_SVH
`define LANE_CHANGE_PLANNER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define LCP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lane change planner check failed");
`define LCP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lane change planner check failed");
`else
`define LCP_ASSERT_IMP(name, ante, cons)
`define LCP_ASSERT_NXT(name, ante, cons)
`endif
`endif

### rtl/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants of the lane change planner.
// ----------------------------------------------------------------------------
package lcp_pkg;

  // Field widths.
  localparam int SPD_W  = 14;
  localparam int GAP_W  = 22;
  localparam int CFG_W  = 21;
  localparam int IDX_W  = 3;
  localparam int IN_W   = 112;
  localparam int OUT_W  = 24;

  // Constants.
  localparam logic [GAP_W-1:0] FAR_GAP       = 22'd2560000;
  localparam logic [SPD_W-1:0] SPEED_CAP     = 14'd16383;
  localparam logic [SPD_W-1:0] MAX_SPEED_RST = 14'd5504;
  localparam int               ROOT_STEPS    = 16;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_MAX_SPEED   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_LANE_COUNT  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_FOLLOW_GAP  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_REAR_GAP    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_CLEAR_GAP   = 3'd4;
  localparam logic [IDX_W-1:0] CFG_SLOW_FACTOR = 3'd5;
  localparam logic [IDX_W-1:0] CFG_SETTLE_BAND = 3'd6;

  // Plan modes.
  localparam logic [1:0] MODE_KEEP    = 2'd0;
  localparam logic [1:0] MODE_PREPARE = 2'd1;
  localparam logic [1:0] MODE_CHANGE  = 2'd2;
  localparam logic [1:0] MODE_SETTLE  = 2'd3;

  // Lane table read selects.
  localparam logic [1:0] RD_REP = 2'd0;
  localparam logic [1:0] RD_LO  = 2'd1;
  localparam logic [1:0] RD_HI  = 2'd2;
  localparam logic [1:0] RD_NOW = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       mul;
    logic       sum;
    logic       step;
    logic       upd;
    logic       score;
    logic       dec;
    logic       load;
    logic [1:0] rd_sel;
  } lcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rep_go;
    logic last;
    logic out_free;
  } lcp_sts_t;

endpackage

### rtl/lane_change_planner_top.sv
// ----------------------------------------------------------------------------
// lane_change_planner_top
// Lane change planner: per-frame nearest car tables and a four-mode plan.
// ----------------------------------------------------------------------------
// Flow: a new beat is taken only once the last one is through; a car report
// runs the bit-serial square root (16 steps) for its speed before its update.
// A closing beat goes on through scoring and decision before its result beat
// shows; the result waits in a register and only the next
// closing beat stalls behind it.
// Reset: rst_n is synchronous, active low; it restores register defaults,
// clears the lane tables to far gaps and puts the plan in keep mode.
`include "lane_change_planner_top_assert.svh"

module lane_change_planner_top #(
  parameter int MAX_LANES    = 4,
  parameter int LANE_WIDTH_M = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // ego_s[20:0], ego_d[36:21], other_s[57:37], other_d[73:58],
  // other_vx[89:74], other_vy[105:90], zero fill [111:106]
  input  logic [lcp_pkg::IN_W-1:0]  in_tdata,
  // report_valid[0]
  input  logic                      in_tuser,
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // goal speed[13:0], lane_position[18:14], plan_mode[20:19],
  // goal_lane[22:21], zero fill [23]
  output logic [lcp_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lcp_pkg::IDX_W-1:0] cfg_index,
  input  logic [lcp_pkg::CFG_W-1:0] cfg_data
);
  import lcp_pkg::*;

  lcp_cmd_t cmd;
  lcp_sts_t sts;

  assign cfg_ready = 1'b1;

  lcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lcp_dp #(
    .MAX_LANES    (MAX_LANES),
    .LANE_WIDTH_M (LANE_WIDTH_M)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata),
    .in_user   (in_tuser),
    .in_last   (in_tlast),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // One beat at a time: the input closes right after a beat is taken.
  `LCP_ASSERT_NXT(a_one_beat, in_tvalid && in_tready, !in_tready)
  // A beat never produces its result in the very next cycle.
  `LCP_ASSERT_NXT(a_no_early_result, in_tvalid && in_tready && !out_tvalid, !out_tvalid)
  // The goal lane is always a lane of the table.
  `LCP_ASSERT_IMP(a_goal_range, out_tvalid, 32'(out_tdata[22:21]) < 32'(MAX_LANES))

endmodule

### rtl/lcp_ctrl.sv
// ----------------------------------------------------------------------------
// lcp_ctrl
// Sequencer of the lane change planner: steps one item through check, for a report
// speed root and table update and, on a closing beat, the plan decision.
// ----------------------------------------------------------------------------
module lcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output lcp_pkg::lcp_cmd_t cmd,
  input  lcp_pkg::lcp_sts_t sts
);
  import lcp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_SC_LO = 4'd6;
  localparam logic [3:0] S_SC_HI = 4'd7;
  localparam logic [3:0] S_SC_NW = 4'd8;
  localparam logic [3:0] S_DEC   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam int CNT_W = $clog2(ROOT_STEPS);

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.rd_sel = RD_REP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.rep_go) state_nxt = S_MUL;
        else if (sts.last) state_nxt = S_SC_LO;
        else state_nxt = S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last ? S_SC_LO : S_IDLE;
      end
      S_SC_LO: begin
        cmd.score  = 1'b1;
        cmd.rd_sel = RD_LO;
        state_nxt  = S_SC_HI;
      end
      S_SC_HI: begin
        cmd.score  = 1'b1;
        cmd.rd_sel = RD_HI;
        state_nxt  = S_SC_NW;
      end
      S_SC_NW: begin
        cmd.score  = 1'b1;
        cmd.rd_sel = RD_NOW;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/lcp_dp.sv
// ----------------------------------------------------------------------------
// lcp_dp
// Datapath of the lane change planner: configuration registers, per-lane
// gap tables, bit-serial speed root, plan state and the result register.
// ----------------------------------------------------------------------------
module lcp_dp #(
  parameter int MAX_LANES    = 4,
  parameter int LANE_WIDTH_M = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcp_pkg::lcp_cmd_t           cmd,
  output lcp_pkg::lcp_sts_t           sts,
  input  logic [lcp_pkg::IN_W-1:0]    in_data,
  input  logic                        in_user,
  input  logic                        in_last,
  input  logic                        cfg_we,
  input  logic [lcp_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [lcp_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lcp_pkg::OUT_W-1:0]   out_data
);
  import lcp_pkg::*;

  localparam int LW    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int OFF_W = $clog2(LANE_WIDTH_M + 1);
  localparam int LW256 = LANE_WIDTH_M * 256;

  // Configuration registers.
  logic [SPD_W-1:0] max_speed_r;
  logic [2:0]       lane_count_r;
  logic [20:0]      follow_gap_r, rear_gap_r, clear_gap_r;
  logic [8:0]       slow_factor_r;
  logic [11:0]      settle_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= MAX_SPEED_RST;
      lane_count_r  <= 3'd3;
      follow_gap_r  <= 21'd7680;
      rear_gap_r    <= 21'd2560;
      clear_gap_r   <= 21'd10240;
      slow_factor_r <= 9'd205;
      settle_band_r <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_SPEED:   max_speed_r   <= cfg_wdata[SPD_W-1:0];
        CFG_LANE_COUNT:  lane_count_r  <= cfg_wdata[2:0];
        CFG_FOLLOW_GAP:  follow_gap_r  <= cfg_wdata;
        CFG_REAR_GAP:    rear_gap_r    <= cfg_wdata;
        CFG_CLEAR_GAP:   clear_gap_r   <= cfg_wdata;
        CFG_SLOW_FACTOR: slow_factor_r <= cfg_wdata[8:0];
        CFG_SETTLE_BAND: settle_band_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Lanes in use, clamped to one through MAX_LANES.
  logic [3:0] used;
  always_comb begin
    if (lane_count_r == 3'd0) used = 4'd1;
    else if (4'(lane_count_r) > 4'(MAX_LANES)) used = 4'(MAX_LANES);
    else used = 4'(lane_count_r);
  end

  // Beat capture.
  logic [20:0]        ego_s_q, oth_s_q;
  logic signed [15:0] ego_d_q, oth_d_q, vx_q, vy_q;
  logic               rep_q, last_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ego_s_q <= in_data[20:0];
      ego_d_q <= in_data[36:21];
      oth_s_q <= in_data[57:37];
      oth_d_q <= in_data[73:58];
      vx_q    <= in_data[89:74];
      vy_q    <= in_data[105:90];
      rep_q   <= in_user;
      last_q  <= in_last;
    end
  end

  // Report lane: the lateral offset in whole metres is compared against
  // multiples of the lane width; slightly negative offsets count as lane 0.
  logic [7:0]    d8;
  logic [LW-1:0] rep_lane;
  logic          lane_ok;
  always_comb begin
    d8       = {1'b0, oth_d_q[14:8]};
    rep_lane = '0;
    for (int k = 1; k < MAX_LANES; k++) begin
      if (d8 >= 8'(k * LANE_WIDTH_M)) rep_lane = LW'(k);
    end
    if (oth_d_q < 0) begin
      rep_lane = '0;
      lane_ok  = (int'(oth_d_q) > -LW256);
    end else begin
      lane_ok  = (d8 < 8'(used) * 8'(LANE_WIDTH_M));
    end
  end

  // Plan state.
  logic [1:0]       mode_r;
  logic [LW-1:0]    now_r, goal_r;
  logic [OFF_W-1:0] off_r;
  logic [SPD_W-1:0] sg_r;
  logic             open_r, skip_r;

  // Per-lane tables, read through one index at a time.
  logic [GAP_W-1:0] ahead_gap_r [MAX_LANES];
  logic [SPD_W-1:0] ahead_spd_r [MAX_LANES];
  logic [GAP_W-1:0] behind_gap_r[MAX_LANES];

  logic [LW-1:0]    rd_idx;
  logic             rd_ok;
  logic [LW:0]      now_p1;
  always_comb begin
    now_p1 = {1'b0, now_r} + 1'b1;
    case (cmd.rd_sel)
      RD_REP: begin
        rd_idx = rep_lane;
        rd_ok  = 1'b1;
      end
      RD_LO: begin
        rd_idx = now_r - 1'b1;
        rd_ok  = (now_r != '0) && (4'(now_r) <= used);
      end
      RD_HI: begin
        rd_idx = now_p1[LW-1:0];
        rd_ok  = (4'(now_p1) < used);
      end
      RD_NOW: begin
        rd_idx = now_r;
        rd_ok  = 1'b1;
      end
      default: begin
        rd_idx = now_r;
        rd_ok  = 1'b1;
      end
    endcase
  end

  logic [GAP_W-1:0] rd_ag, rd_bg;
  logic [SPD_W-1:0] rd_as, rd_score;
  assign rd_ag = ahead_gap_r[rd_idx];
  assign rd_bg = behind_gap_r[rd_idx];
  assign rd_as = ahead_spd_r[rd_idx];

  // Lane score of the entry on the read index.
  always_comb begin
    if (!rd_ok) rd_score = '0;
    else if (rd_bg <= GAP_W'(rear_gap_r) || rd_ag <= GAP_W'(follow_gap_r)) rd_score = '0;
    else if (rd_ag <= GAP_W'(clear_gap_r)) rd_score = rd_as;
    else rd_score = max_speed_r;
  end

  // Speed root: squares, sum, then one result bit a cycle.
  logic signed [31:0] vx2_r, vy2_r;
  logic [31:0]        sq_r;
  logic [17:0]        rem_r, rem_sh, trial;
  logic [15:0]        root_r;
  logic [SPD_W-1:0]   rep_spd;

  assign rem_sh  = {rem_r[15:0], sq_r[31:30]};
  assign trial   = {root_r, 2'b01};
  assign rep_spd = (root_r > 16'(SPEED_CAP)) ? SPEED_CAP : root_r[SPD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      vx2_r <= vx_q * vx_q;
      vy2_r <= vy_q * vy_q;
    end
    if (cmd.sum) begin
      sq_r   <= $unsigned(vx2_r) + $unsigned(vy2_r);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.step) begin
      sq_r <= {sq_r[29:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[14:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[14:0], 1'b0};
      end
    end
  end

  // Signed distance along the road and its magnitude.
  logic signed [21:0] s_gap;
  logic [GAP_W-1:0]   dist_abs;
  assign s_gap    = $signed({1'b0, oth_s_q}) - $signed({1'b0, ego_s_q});
  assign dist_abs = (s_gap > 0) ? GAP_W'(s_gap) : GAP_W'(-s_gap);

  // Table writes: clear on the start of an unskipped frame, nearest car update on a report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LANES; i++) begin
        ahead_gap_r[i]  <= FAR_GAP;
        ahead_spd_r[i]  <= MAX_SPEED_RST;
        behind_gap_r[i] <= FAR_GAP;
      end
    end else if (cmd.accept && !open_r && sg_r != '0) begin
      for (int i = 0; i < MAX_LANES; i++) begin
        ahead_gap_r[i]  <= FAR_GAP;
        ahead_spd_r[i]  <= max_speed_r;
        behind_gap_r[i] <= FAR_GAP;
      end
    end else if (cmd.upd) begin
      if (s_gap > 0) begin
        if (dist_abs < rd_ag) begin
          ahead_gap_r[rd_idx] <= dist_abs;
          ahead_spd_r[rd_idx] <= rep_spd;
        end
      end else if (dist_abs < rd_bg) begin
        behind_gap_r[rd_idx] <= dist_abs;
      end
    end
  end

  // Scores of the neighbor lanes and the own lane state.
  logic [SPD_W-1:0] sc_lo_r, sc_hi_r, spd_now_r;
  logic             free_now_r;
  always_ff @(posedge clk) begin
    if (cmd.score) begin
      case (cmd.rd_sel)
        RD_LO: sc_lo_r <= rd_score;
        RD_HI: sc_hi_r <= rd_score;
        RD_NOW: begin
          spd_now_r  <= rd_as;
          free_now_r <= (rd_ag >= GAP_W'(follow_gap_r));
        end
        default: ;
      endcase
    end
  end

  // Lateral target in metres.
  logic [7:0] pos;
  assign pos = 8'(LANE_WIDTH_M) * 8'(now_r) + 8'(off_r);

  // Settle window around the lane target.
  logic in_band;
  always_comb begin
    in_band = (int'(pos) * 256 - int'(settle_band_r) < int'(ego_d_q)) &&
              (int'(ego_d_q) < int'(pos) * 256 + int'(settle_band_r));
  end

  // Prepare step: pick the best of left, own and right.
  logic [SPD_W-1:0] best;
  logic [LW-1:0]    pick;
  logic [22:0]      slow_prod;
  logic [14:0]      slow;
  always_comb begin
    best = '0;
    pick = goal_r;
    if (sc_lo_r > best) begin
      pick = now_r - 1'b1;
      best = sc_lo_r;
    end
    if (sg_r > best) begin
      pick = now_r;
      best = sg_r;
    end
    if (sc_hi_r > best) begin
      pick = now_p1[LW-1:0];
    end
    slow_prod = 23'(sg_r) * 23'(slow_factor_r);
    slow      = slow_prod[22:8];
  end

  // Frame flags and plan step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_KEEP;
      now_r  <= LW'(1);
      goal_r <= LW'(1);
      off_r  <= OFF_W'(LANE_WIDTH_M / 2);
      sg_r   <= MAX_SPEED_RST;
      open_r <= 1'b0;
      skip_r <= 1'b0;
    end else if (cmd.accept) begin
      if (!open_r) begin
        open_r <= 1'b1;
        skip_r <= (sg_r == '0);
      end
    end else if (cmd.dec) begin
      open_r <= 1'b0;
      skip_r <= 1'b0;
      if (skip_r) begin
        sg_r <= max_speed_r;
      end else begin
        case (mode_r)
          MODE_KEEP: begin
            if (free_now_r) begin
              sg_r <= max_speed_r;
            end else begin
              sg_r <= spd_now_r;
              if (sc_lo_r > spd_now_r || sc_hi_r > spd_now_r) mode_r <= MODE_PREPARE;
            end
          end
          MODE_PREPARE: begin
            goal_r <= pick;
            if (pick == now_r) begin
              mode_r <= MODE_KEEP;
            end else begin
              sg_r   <= (slow > 15'(SPEED_CAP)) ? SPEED_CAP : slow[SPD_W-1:0];
              mode_r <= MODE_CHANGE;
            end
          end
          MODE_CHANGE: begin
            off_r  <= (goal_r < now_r) ? OFF_W'(LANE_WIDTH_M) : '0;
            now_r  <= goal_r;
            mode_r <= MODE_SETTLE;
          end
          default: begin
            if (in_band) begin
              now_r  <= goal_r;
              off_r  <= OFF_W'(LANE_WIDTH_M / 2);
              mode_r <= MODE_KEEP;
            end
          end
        endcase
      end
    end
  end

  // Result register.
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {1'b0, 2'(goal_r), mode_r, pos[4:0], sg_r};
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.rep_go   = rep_q && !skip_r && lane_ok;
  assign sts.last     = last_q;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

### tb/lane_change_planner_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_change_planner_checker
// Watches the input, result and register channels of the lane change planner,
// keeps its own copy of the frame tables and the lane plan, and compares each
// result beat field by field with the oldest predicted plan.
// ----------------------------------------------------------------------------
module lane_change_planner_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [lcp_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tuser,
  input  logic                      in_tlast,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [lcp_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [lcp_pkg::IDX_W-1:0] cfg_index,
  input  logic [lcp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      run_done,
  output int                        fail_count,
  output int                        plans_pending,
  output int                        plans_seen
);
  import lcp_pkg::*;

  localparam int LANES = 4;
  localparam int LW = 4;

  // Fields from the highest bit down, so the lowest field sits at bit 0.
  typedef struct packed {
    logic [1:0]  goal_lane;
    logic [1:0]  plan_mode;
    logic [4:0]  lane_position;
    logic [13:0] speed_val;
  } plan_t;

  plan_t plan_q[$];

  // Register copies.
  logic [13:0] r_max_speed;
  logic [2:0]  r_lane_count;
  logic [20:0] r_follow, r_rear, r_clear;
  logic [8:0]  r_slow;
  logic [11:0] r_band;

  // Frame tables and plan state.
  logic [21:0] gap_ahead [LANES];
  logic [13:0] spd_ahead [LANES];
  logic [21:0] gap_behind[LANES];
  logic [1:0]  p_mode, p_now, p_goal;
  logic [2:0]  p_offset;
  logic [13:0] p_speed;
  logic        f_open, f_skip;
  logic        leftover_done;

  function automatic int lanes_used();
    int n;
    n = r_lane_count;
    if (n < 1) n = 1;
    if (n > LANES) n = LANES;
    return n;
  endfunction

  function automatic logic [31:0] root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] lane_merit(int ln);
    if (ln < 0 || ln >= lanes_used()) return 0;
    if (gap_behind[ln] <= r_rear || gap_ahead[ln] <= r_follow) return 0;
    if (gap_ahead[ln] <= r_clear) return spd_ahead[ln];
    return r_max_speed;
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < LANES; i++) begin
      gap_ahead[i] = FAR_GAP;
      spd_ahead[i] = r_max_speed;
      gap_behind[i] = FAR_GAP;
    end
  endtask

  // Nearest car update from one report beat.
  task automatic note_car(logic [IN_W-1:0] d);
    longint cd, ln, s_gap, vx, vy;
    longint unsigned sq;
    logic [31:0] spd;
    cd = $signed(d[73:58]);
    if (cd < 0) begin
      if (cd <= -LW * 256) return;
      ln = 0;
    end else begin
      ln = cd / (LW * 256);
    end
    if (ln >= lanes_used()) return;
    s_gap = longint'(d[57:37]) - longint'(d[20:0]);
    vx = $signed(d[89:74]);
    vy = $signed(d[105:90]);
    sq = vx * vx + vy * vy;
    spd = root_floor(sq);
    if (spd > 16383) spd = 16383;
    if (s_gap > 0) begin
      if (s_gap < gap_ahead[ln]) begin
        gap_ahead[ln] = s_gap[21:0];
        spd_ahead[ln] = spd[13:0];
      end
    end else if (-s_gap < gap_behind[ln]) begin
      gap_behind[ln] = 22'(-s_gap);
    end
  endtask

  // One plan step on the closing beat.
  task automatic plan_step(logic [15:0] ego_d);
    int now;
    logic [31:0] sc[3];
    logic [31:0] best;
    longint unsigned s;
    longint c, ed;
    now = p_now;
    case (p_mode)
      MODE_KEEP: begin
        if (gap_ahead[p_now] >= r_follow) begin
          p_speed = r_max_speed;
        end else begin
          p_speed = spd_ahead[p_now];
          if (lane_merit(now - 1) > p_speed || lane_merit(now + 1) > p_speed)
            p_mode = MODE_PREPARE;
        end
      end
      MODE_PREPARE: begin
        sc[0] = lane_merit(now - 1);
        sc[1] = p_speed;
        sc[2] = lane_merit(now + 1);
        best = 0;
        for (int i = 0; i < 3; i++) begin
          if (sc[i] > best) begin
            p_goal = 2'(now + i - 1);
            best = sc[i];
          end
        end
        if (p_goal == p_now) begin
          p_mode = MODE_KEEP;
        end else begin
          s = (longint'(p_speed) * r_slow) >> 8;
          p_speed = (s > 16383) ? 14'd16383 : s[13:0];
          p_mode = MODE_CHANGE;
        end
      end
      MODE_CHANGE: begin
        p_offset = (p_goal < p_now) ? 3'(LW) : 3'd0;
        p_now = p_goal;
        p_mode = MODE_SETTLE;
      end
      default: begin
        // Keep the whole window check in signed arithmetic.
        c = (longint'(LW) * longint'(p_now) + longint'(p_offset)) * 256;
        ed = longint'($signed(ego_d));
        if (c - longint'(r_band) < ed && ed < c + longint'(r_band)) begin
          p_now = p_goal;
          p_offset = 3'(LW / 2);
          p_mode = MODE_KEEP;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("tb: mismatch in %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    plan_t exp_plan, got;
    if (!rst_n) begin
      r_max_speed = 14'd5504;
      r_lane_count = 3'd3;
      r_follow = 21'd7680;
      r_rear = 21'd2560;
      r_clear = 21'd10240;
      r_slow = 9'd205;
      r_band = 12'd256;
      clear_tables();
      p_mode = MODE_KEEP;
      p_now = 2'd1;
      p_goal = 2'd1;
      p_offset = 3'(LW / 2);
      p_speed = 14'd5504;
      f_open = 0;
      f_skip = 0;
      leftover_done = 0;
      fail_count = 0;
      plans_seen = 0;
      plan_q.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_SPEED:   r_max_speed = cfg_data[13:0];
          CFG_LANE_COUNT:  r_lane_count = cfg_data[2:0];
          CFG_FOLLOW_GAP:  r_follow = cfg_data;
          CFG_REAR_GAP:    r_rear = cfg_data;
          CFG_CLEAR_GAP:   r_clear = cfg_data;
          CFG_SLOW_FACTOR: r_slow = cfg_data[8:0];
          CFG_SETTLE_BAND: r_band = cfg_data[11:0];
          default: ;
        endcase
      end
      // Input beats.
      if (in_tvalid && in_tready) begin
        if (!f_open) begin
          f_open = 1;
          f_skip = (p_speed == 0);
          if (!f_skip) clear_tables();
        end
        if (in_tuser && !f_skip) note_car(in_tdata);
        if (in_tlast) begin
          if (f_skip) p_speed = r_max_speed;
          else plan_step(in_tdata[36:21]);
          f_open = 0;
          f_skip = 0;
          exp_plan.speed_val = p_speed;
          exp_plan.lane_position = 5'(LW * p_now + p_offset);
          exp_plan.plan_mode = p_mode;
          exp_plan.goal_lane = p_goal;
          plan_q = {plan_q, exp_plan};
        end
      end
      // Result beats.
      if (out_tvalid && out_tready) begin
        got = out_tdata[22:0];
        plans_seen++;
        if (plan_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          exp_plan = plan_q.pop_front();
          if (got.speed_val != exp_plan.speed_val)
            report_mismatch("goal speed", got.speed_val, exp_plan.speed_val);
          if (got.lane_position != exp_plan.lane_position)
            report_mismatch("lane_position", got.lane_position, exp_plan.lane_position);
          if (got.plan_mode != exp_plan.plan_mode)
            report_mismatch("plan_mode", got.plan_mode, exp_plan.plan_mode);
          if (got.goal_lane != exp_plan.goal_lane)
            report_mismatch("goal_lane", got.goal_lane, exp_plan.goal_lane);
        end
      end
      // Plans still owed at the end count as failures.
      if (run_done && !leftover_done) begin
        leftover_done = 1;
        if (plan_q.size() != 0) report_mismatch("plans left over", plan_q.size(), 0);
      end
    end
    plans_pending = plan_q.size();
  end
endmodule

### tb/lane_change_planner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_change_planner_top_tb
// Drives frames of car reports into the lane change planner under random
// sender gaps and receiver stalls, across several register settings, and
// takes the verdict from the checker module.
// ----------------------------------------------------------------------------
module lane_change_planner_top_tb;
  import lcp_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tuser;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              run_done;
  int                fail_count;
  int                plans_pending;
  int                plans_seen;
  int                idle_cycles;

  lane_change_planner_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lane_change_planner_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .run_done(run_done),
    .fail_count(fail_count), .plans_pending(plans_pending), .plans_seen(plans_seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver stall pattern: phases of steady acceptance and of random stalls.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 100) out_tready <= 1'b1;
      else if (stall_phase < 250) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog on cycles with no beat accepted anywhere.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  int burst_left;
  logic steady;

  // One beat, with a random gap ahead of it when a burst runs out outside steady mode.
  task automatic send_beat(logic [20:0] es, logic [15:0] ed, logic [20:0] os,
                           logic [15:0] od, logic [15:0] vx, logic [15:0] vy,
                           logic rep, logic last);
    if (!steady && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, vy, vx, od, os, ed, es};
    in_tuser <= rep;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (plans_pending != 0) @(posedge clk);
    // A beat without a result may still be in flight.
    repeat (40) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_valid after the last one.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_all(int ms, int lc, int fg, int rg, int cg, int sf, int sb);
    write_reg(CFG_MAX_SPEED, CFG_W'(ms));
    write_reg(CFG_LANE_COUNT, CFG_W'(lc));
    write_reg(CFG_FOLLOW_GAP, CFG_W'(fg));
    write_reg(CFG_REAR_GAP, CFG_W'(rg));
    write_reg(CFG_CLEAR_GAP, CFG_W'(cg));
    write_reg(CFG_SLOW_FACTOR, CFG_W'(sf));
    write_reg(CFG_SETTLE_BAND, CFG_W'(sb));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A random frame shaped to fill the gap tables around the ego car.
  task automatic send_frame(int cars, int ego_lane);
    logic [20:0] es, os;
    logic [15:0] ed, od, vx, vy;
    int ofs;
    logic rep;
    es = $urandom_range(40000, 2057151);
    ed = 16'(ego_lane * 1024 + $urandom_range(0, 1023));
    if ($urandom_range(0, 3) == 0) ed = 16'($urandom);
    for (int k = 0; k <= cars; k++) begin
      ofs = $urandom_range(0, 3) == 0 ? $signed($urandom_range(0, 40000)) - 20000
                                      : $signed($urandom_range(0, 16000)) - 4000;
      os = 21'(int'(es) + ofs);
      if ($urandom_range(0, 9) == 0) os = 21'($urandom);
      od = $urandom_range(0, 9) == 0 ? 16'($urandom)
                                     : 16'($signed($urandom_range(0, 5119)) - 1024);
      vx = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6000));
      vy = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 800));
      rep = ($urandom_range(0, 7) != 0);
      send_beat(es, ed, os, od, vx, vy, rep, k == cars);
    end
  endtask

  int sent;

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_SPEED;
    cfg_data = '0;
    run_done = 1'b0;
    burst_left = 0;
    steady = 1'b1;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, negative lateral positions, bare close beats.
    send_beat(21'd0, 16'h8000, 21'h1FFFFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_beat(21'h1FFFFF, 16'h7FFF, 21'd0, 16'hFC01, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    send_beat(21'd1000, 16'd1500, 21'd1000, 16'hFC00, 16'd100, 16'd0, 1'b1, 1'b0);
    send_beat(21'd1000, 16'd1500, 21'd3000, 16'd1024, 16'd1000, 16'd0, 1'b1, 1'b0);
    send_beat(21'd1000, 16'd1500, 21'd500, 16'd2048, 16'd0, 16'd0, 1'b0, 1'b0);
    send_beat(21'd1000, 16'd1500, 21'd1000, 16'd3100, 16'd7, 16'd9, 1'b0, 1'b1);
    // Slow car right ahead: drive the plan through prepare, change and settle.
    for (int k = 0; k < 6; k++)
      send_beat(21'd5000, 16'd1536, 21'd6000, 16'd1500, 16'd1000, 16'd0, 1'b1, 1'b1);
    send_beat(21'd5000, 16'd512, 21'd6000, 16'd100, 16'd0, 16'd0, 1'b0, 1'b1);
    send_beat(21'd5000, 16'd2560, 21'd6000, 16'd100, 16'd0, 16'd0, 1'b0, 1'b1);
    go_idle();

    // Zero goal speed makes the next frame skipped.
    write_all(0, 4, 0, 0, 0, 256, 2048);
    send_beat(21'd10, 16'd0, 21'd20, 16'd10, 16'd5, 16'd5, 1'b1, 1'b1);
    send_beat(21'd10, 16'd0, 21'd20, 16'd10, 16'd5, 16'd5, 1'b1, 1'b1);
    send_beat(21'd10, 16'd0, 21'd20, 16'd10, 16'd5, 16'd5, 1'b1, 1'b1);
    go_idle();
    write_all(16383, 7, 2097151, 2097151, 2097151, 0, 0);
    send_beat(21'd10, 16'd0, 21'd20, 16'd10, 16'd5, 16'd5, 1'b1, 1'b1);
    send_beat(21'd10, 16'd0, 21'd20, 16'd10, 16'd5, 16'd5, 1'b0, 1'b1);
    go_idle();
    write_all(0, 0, 0, 0, 0, 0, 0);
    send_beat(21'd10, 16'd0, 21'd20, 16'd10, 16'd5, 16'd5, 1'b1, 1'b1);
    go_idle();

    // Random phases over several register settings.
    steady = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(5504, 3, 7680, 2560, 10240, 205, 256);
        1: write_all(16383, 4, 6000, 1000, 9000, 256, 2048);
        2: write_all($urandom_range(1000, 9000), 2, 4000, 500, 6000, 128, 512);
        3: write_all(8000, 1, 8000, 2000, 12000, 230, 1024);
        4: write_all($urandom_range(0, 16383), $urandom_range(0, 7),
                     $urandom_range(0, 20000), $urandom_range(0, 5000),
                     $urandom_range(0, 20000), $urandom_range(0, 256),
                     $urandom_range(0, 2048));
        default: write_all(5504, 3, 7680, 2560, 10240, 205, 256);
      endcase
      sent = 0;
      while (sent < 300) begin
        send_frame($urandom_range(0, 8), $urandom_range(0, 3));
        sent += 5;
        // Hold off until every plan has come back, now and then.
        if ($urandom_range(0, 19) == 0) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (plans_pending != 0) @(posedge clk);
        end
      end
      go_idle();
    end

    go_idle();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/lcp_pkg.sv
rtl/lcp_ctrl.sv
rtl/lcp_dp.sv
rtl/lane_change_planner_top.sv
tb/lane_change_planner_checker.sv
tb/lane_change_planner_top_tb.sv
